FILE: rtl/afp_pkg.sv
// ----------------------------------------------------------------------------
// afp_pkg - acquisition frame parser shared definitions
// Result codes, result entry type, frame layout constants and bus widths.
// ----------------------------------------------------------------------------
package afp_pkg;

   // result kinds
   localparam logic [1:0] KIND_IO      = 2'd0;
   localparam logic [1:0] KIND_ADC     = 2'd1;
   localparam logic [1:0] KIND_CAN     = 2'd2;
   localparam logic [1:0] KIND_BAD_CAN = 2'd3;

   // message types
   localparam logic [7:0] MSG_TYPE_CAN = 8'd1;
   localparam logic [7:0] MSG_TYPE_ADC = 8'd2;

   // frame layout
   localparam int PAYLOAD_START   = 16 + 64;
   localparam int RECORD_BYTES    = 25;
   localparam int TICKS_PER_ROUND = 10;
   localparam logic [15:0] POS_IO_BITS = 16'd13;
   localparam logic [15:0] POS_TYPE    = 16'd14;
   localparam logic [15:0] POS_LIMIT   = 16'hFFFF;

   // parameter defaults
   localparam int MAX_PAYLOAD_BYTES_DEF = 4096;
   localparam int ADC_CHANNELS_DEF      = 4;

   // bus widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_FIELD_W = 2 + 32 + 16 + 32 + 64;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;
   localparam int RSP_TUSER_W = 2;

   // one queued result; io_pair marks the two IO lines carried in one entry
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  channel;
      logic [31:0] timestamp;
      logic [15:0] sample_value;
      logic [31:0] can_identifier;
      logic [63:0] can_payload;
      logic        io_pair;
   } result_entry_type;

endpackage

FILE: rtl/afp_parser.sv
// ----------------------------------------------------------------------------
// afp_parser - byte-wise message decoder
// Tracks the byte position and header/record state and builds at most one
// result entry per accepted byte.
// ----------------------------------------------------------------------------
module afp_parser
   import afp_pkg::*;
#(
   parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
   parameter int ADC_CHANNELS      = ADC_CHANNELS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_accept,
   input  logic [7:0]       msg_byte,
   input  logic             msg_end,
   input  logic             csr_write,
   input  logic [31:0]      csr_wdata,
   output logic             res_valid,
   output result_entry_type res_entry
);

   localparam int ChanW = (ADC_CHANNELS > 1) ? $clog2(ADC_CHANNELS) : 1;
   localparam logic [ChanW-1:0] ChanLast = ChanW'(ADC_CHANNELS - 1);
   localparam logic [4:0] RecLast = 5'(RECORD_BYTES - 1);

   function automatic logic [31:0] put_byte(input logic [31:0] word,
                                            input logic [1:0] lane,
                                            input logic [7:0] b);
      logic [31:0] r;
      r = word;
      for (int j = 0; j < 4; j++) begin
         if (lane == 2'(j)) r[j*8 +: 8] = b;
      end
      return r;
   endfunction

   logic [31:0]      offset_ff;
   logic [15:0]      pos_ff, pos_in;
   logic [31:0]      header_time_ff, header_time_in;
   logic [31:0]      payload_length_ff, payload_length_in;
   logic [7:0]       message_type_ff, message_type_in;
   logic [7:0]       sample_high_ff, sample_high_in;
   logic [7:0]       record_channel_ff, record_channel_in;
   logic [31:0]      record_time_ff, record_time_in;
   logic [31:0]      record_identifier_ff, record_identifier_in;
   logic [63:0]      record_payload_ff, record_payload_in;
   logic [4:0]       record_index_ff, record_index_in;
   logic [ChanW-1:0] adc_chan_ff, adc_chan_in;
   logic [31:0]      adc_time_ff, adc_time_in;

   logic [31:0]      msg_time, adc_time, can_time;
   logic             frame_positive, in_payload, in_bound;
   logic [15:0]      idx;
   logic [1:0]       rec_lane;
   logic [ChanW+1:0] chan_wide;

   assign msg_time       = header_time_ff - offset_ff;
   assign adc_time       = adc_time_ff - offset_ff;
   assign can_time       = record_time_ff - offset_ff;
   assign frame_positive = (msg_time != '0) && !msg_time[31];
   assign idx            = pos_ff - 16'(PAYLOAD_START);
   assign in_payload     = (pos_ff >= 16'(PAYLOAD_START)) && (pos_ff != POS_LIMIT);
   assign in_bound       = in_payload && !payload_length_ff[31]
                           && ({16'b0, idx} < payload_length_ff)
                           && ({16'b0, idx} < 32'(MAX_PAYLOAD_BYTES));
   assign rec_lane       = record_index_ff[1:0] - 2'd1;
   assign chan_wide      = {2'b00, adc_chan_ff};

   always_comb begin
      pos_in               = pos_ff;
      header_time_in       = header_time_ff;
      payload_length_in    = payload_length_ff;
      message_type_in      = message_type_ff;
      sample_high_in       = sample_high_ff;
      record_channel_in    = record_channel_ff;
      record_time_in       = record_time_ff;
      record_identifier_in = record_identifier_ff;
      record_payload_in    = record_payload_ff;
      record_index_in      = record_index_ff;
      adc_chan_in          = adc_chan_ff;
      adc_time_in          = adc_time_ff;
      res_valid            = 1'b0;
      res_entry            = '0;

      if (byte_accept) begin
         if (pos_ff >= 16'd4 && pos_ff <= 16'd7) begin
            header_time_in = put_byte(header_time_ff, pos_ff[1:0], msg_byte);
            adc_time_in    = header_time_in;
         end else if (pos_ff >= 16'd8 && pos_ff <= 16'd11) begin
            payload_length_in = put_byte(payload_length_ff, pos_ff[1:0], msg_byte);
         end else if (pos_ff == POS_IO_BITS) begin
            res_valid              = 1'b1;
            res_entry.kind         = KIND_IO;
            res_entry.timestamp    = msg_time;
            res_entry.sample_value = {14'b0, msg_byte[1:0]};
            res_entry.io_pair      = 1'b1;
         end else if (pos_ff == POS_TYPE) begin
            message_type_in = msg_byte;
         end else if (in_payload) begin
            // sample pair counters follow the byte index, odd byte closes a pair
            if (idx[0]) begin
               if (adc_chan_ff == ChanLast) begin
                  adc_chan_in = '0;
                  adc_time_in = adc_time_ff + 32'(TICKS_PER_ROUND);
               end else begin
                  adc_chan_in = adc_chan_ff + ChanW'(1);
               end
            end
            if (in_bound) begin
               if (message_type_ff == MSG_TYPE_ADC) begin
                  if (!idx[0]) begin
                     sample_high_in = msg_byte;
                  end else if (frame_positive) begin
                     res_valid              = 1'b1;
                     res_entry.kind         = KIND_ADC;
                     res_entry.channel      = chan_wide[1:0];
                     res_entry.timestamp    = adc_time;
                     res_entry.sample_value = {sample_high_ff, msg_byte};
                  end
               end else if (message_type_ff == MSG_TYPE_CAN) begin
                  if (record_index_ff == 5'd0) begin
                     record_channel_in = msg_byte;
                  end else if (record_index_ff <= 5'd4) begin
                     record_time_in = put_byte(record_time_ff, rec_lane, msg_byte);
                  end else if (record_index_ff >= 5'd9 && record_index_ff <= 5'd12) begin
                     record_identifier_in = put_byte(record_identifier_ff, rec_lane,
                                                     msg_byte);
                  end else if (record_index_ff >= 5'd16 && record_index_ff <= 5'd23) begin
                     record_payload_in = {record_payload_ff[55:0], msg_byte};
                  end else if (record_index_ff == RecLast && frame_positive) begin
                     res_valid = 1'b1;
                     if (record_channel_ff == 8'd1 || record_channel_ff == 8'd2) begin
                        res_entry.kind           = KIND_CAN;
                        res_entry.channel        = record_channel_ff[1:0];
                        res_entry.timestamp      = can_time;
                        res_entry.can_identifier = record_identifier_ff;
                        res_entry.can_payload    = record_payload_ff;
                     end else begin
                        res_entry.kind = KIND_BAD_CAN;
                     end
                  end
                  record_index_in = (record_index_ff >= RecLast) ? 5'd0
                                                                 : record_index_ff + 5'd1;
               end
            end
         end

         if (pos_ff != POS_LIMIT) pos_in = pos_ff + 16'd1;

         if (msg_end) begin
            pos_in               = '0;
            header_time_in       = '0;
            payload_length_in    = '0;
            message_type_in      = '0;
            sample_high_in       = '0;
            record_channel_in    = '0;
            record_time_in       = '0;
            record_identifier_in = '0;
            record_payload_in    = '0;
            record_index_in      = '0;
            adc_chan_in          = '0;
            adc_time_in          = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff            <= '0;
         pos_ff               <= '0;
         header_time_ff       <= '0;
         payload_length_ff    <= '0;
         message_type_ff      <= '0;
         sample_high_ff       <= '0;
         record_channel_ff    <= '0;
         record_time_ff       <= '0;
         record_identifier_ff <= '0;
         record_payload_ff    <= '0;
         record_index_ff      <= '0;
         adc_chan_ff          <= '0;
         adc_time_ff          <= '0;
      end else begin
         if (csr_write) offset_ff <= csr_wdata;
         pos_ff               <= pos_in;
         header_time_ff       <= header_time_in;
         payload_length_ff    <= payload_length_in;
         message_type_ff      <= message_type_in;
         sample_high_ff       <= sample_high_in;
         record_channel_ff    <= record_channel_in;
         record_time_ff       <= record_time_in;
         record_identifier_ff <= record_identifier_in;
         record_payload_ff    <= record_payload_in;
         record_index_ff      <= record_index_in;
         adc_chan_ff          <= adc_chan_in;
         adc_time_ff          <= adc_time_in;
      end
   end

endmodule

FILE: rtl/afp_out_queue.sv
// ----------------------------------------------------------------------------
// afp_out_queue - two-entry result queue
// Holds decoded entries and sends them as words; an IO pair entry goes out
// as two words, line 0 then line 1.
// ----------------------------------------------------------------------------
module afp_out_queue
   import afp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  result_entry_type wr_entry,
   output logic             full,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [1:0]       out_kind,
   output logic [1:0]       out_channel,
   output logic [31:0]      out_timestamp,
   output logic [15:0]      out_sample_value,
   output logic [31:0]      out_can_identifier,
   output logic [63:0]      out_can_payload,
   output logic             out_last
);

   result_entry_type entries_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;
   logic             phase_ff;
   result_entry_type head;
   logic             send, pop;

   assign head      = entries_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign send      = out_valid && out_ready;
   assign pop       = send && (!head.io_pair || phase_ff);
   assign count_in  = count_ff + {1'b0, wr_en} - {1'b0, pop};

   always_comb begin
      out_kind           = head.kind;
      out_channel        = head.channel;
      out_timestamp      = head.timestamp;
      out_sample_value   = head.sample_value;
      out_can_identifier = head.can_identifier;
      out_can_payload    = head.can_payload;
      out_last           = 1'b1;
      if (head.io_pair) begin
         out_channel      = {1'b0, phase_ff};
         out_sample_value = {15'b0, phase_ff ? head.sample_value[1] : head.sample_value[0]};
         out_last         = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) entries_ff[wr_ptr_ff] <= wr_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         if (wr_en) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
         if (send && head.io_pair) phase_ff <= !phase_ff;
      end
   end

endmodule

FILE: rtl/acquisition_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// acquisition_frame_parser_unit - acquisition message parser top level
// Decodes IO bits, ADC samples and CAN records from a byte stream.
//
//  port group | dir | handshake         | contents
//  req_       | in  | tvalid/tready     | message byte, tlast = end of message
//  rsp_       | out | tvalid/tready     | result word, tuser = kind, tlast = last
//  csr_       | in  | valid/ready       | head time offset (ready always high)
//
// One byte is taken per cycle while the result queue is not full; a byte that
// yields a result writes one queue entry. The IO byte (byte 13) is held as one
// queue entry and leaves as two words, line 0 then line 1. req_tready drops
// only while the two-entry result queue is full, which needs rsp_tready held
// low; with rsp_tready high every byte is taken back to back. Synchronous
// reset clears all message state and the offset.
// ----------------------------------------------------------------------------
module acquisition_frame_parser_unit
   import afp_pkg::*;
#(
   parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
   parameter int ADC_CHANNELS      = ADC_CHANNELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] message_byte
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] channel, [33:2] timestamp, [49:34] sample_value,
   // [81:50] can_identifier, [145:82] can_payload, rest zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // [1:0] kind
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [31:0]            csr_data
);

   logic             byte_accept, res_valid, queue_full;
   result_entry_type res_entry;
   logic [1:0]       out_channel;
   logic [31:0]      out_timestamp, out_can_identifier;
   logic [15:0]      out_sample_value;
   logic [63:0]      out_can_payload;

   assign req_tready  = !queue_full;
   assign csr_ready   = 1'b1;
   assign byte_accept = req_tvalid && req_tready;

   afp_parser #(
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
      .ADC_CHANNELS      (ADC_CHANNELS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .msg_byte    (req_tdata[7:0]),
      .msg_end     (req_tlast),
      .csr_write   (csr_valid && csr_ready),
      .csr_wdata   (csr_data),
      .res_valid   (res_valid),
      .res_entry   (res_entry)
   );

   afp_out_queue u_queue (
      .clock              (clock),
      .reset              (reset),
      .wr_en              (res_valid),
      .wr_entry           (res_entry),
      .full               (queue_full),
      .out_valid          (rsp_tvalid),
      .out_ready          (rsp_tready),
      .out_kind           (rsp_tuser),
      .out_channel        (out_channel),
      .out_timestamp      (out_timestamp),
      .out_sample_value   (out_sample_value),
      .out_can_identifier (out_can_identifier),
      .out_can_payload    (out_can_payload),
      .out_last           (rsp_tlast)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, out_can_payload, out_can_identifier,
                       out_sample_value, out_timestamp, out_channel};

endmodule

FILE: rtl/afp_checker.sv
// ----------------------------------------------------------------------------
// afp_checker - port-level checks for the acquisition frame parser
// Watches the result port for reset, hold and word-shape rules.
// ----------------------------------------------------------------------------
module afp_checker
   import afp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser,
   input logic                   rsp_tlast
);

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word shown after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // IO words come as line 0 then line 1, line 1 closes the run
   a_io_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_IO |-> rsp_tlast == rsp_tdata[0] && !rsp_tdata[1])
      else $error("IO word line and last flag disagree");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_IO |-> rsp_tlast)
      else $error("single result word without last flag");

   a_bad_can: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_BAD_CAN |-> rsp_tdata == '0)
      else $error("bad channel word carries data");

endmodule

bind acquisition_frame_parser_unit afp_checker u_afp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
